[src/bbb_pkg.sv]
// shared types and constants of the bad-block bitmap
// used by bbb_mem, bbb_acc and bad_block_bitmap; no dependencies
package bbb_pkg;

   localparam int MAP_BYTES = 4096;
   localparam int ADDR_W    = $clog2(MAP_BYTES);
   localparam int SIZE_W    = ADDR_W + 1;
   localparam int CNT_W     = 16;
   localparam int POS_W     = 15;
   localparam int CFG_W     = 16;
   localparam int REQ_W     = 48;
   localparam int RSP_W     = 40;
   localparam int RES_W     = 35;

   typedef enum logic [2:0] {
      OP_SET       = 3'd0,
      OP_CLEAR     = 3'd1,
      OP_READ      = 3'd2,
      OP_COUNT     = 3'd3,
      OP_RECOUNT   = 3'd4,
      OP_CLEAR_ALL = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_SAME  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

   typedef struct packed {
      logic clear;
      logic add;
   } acc_ctl_type;

endpackage

[src/bad_block_bitmap.sv]
// bad-block bitmap top level: sequencer, counters and stream ports
// depends on bbb_pkg, bbb_mem and bbb_acc
// set, clear, read: store read, then modify and write back
// count range and recount: one byte per cycle through the popcount unit
// clear all: one byte per cycle written through the store's write port
// reset: synchronous; a clearing pass over the whole store follows, req_tready low meanwhile
module bad_block_bitmap
   import bbb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // opcode, bit_position, start_byte, end_byte
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // status, bit_value, range_count, used_count
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POINT,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type         state_ff;
   logic [2:0]        op_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [SIZE_W-1:0] cnt_ff;
   logic [SIZE_W-1:0] end_ff;
   logic              pend_ff;
   logic              clamp_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic              clr_rsp_ff;
   logic [CNT_W-1:0]  used_ff;
   logic [CNT_W-1:0]  used_in;
   logic [SIZE_W-1:0] size_ff;
   logic              rsp_valid_ff;
   logic [RES_W-1:0]  rsp_data_ff;
   logic [RES_W-1:0]  res_data_ff;

   logic [2:0]        req_op;
   logic [POS_W-1:0]  req_pos;
   logic [SIZE_W-1:0] req_start;
   logic [SIZE_W-1:0] req_end;
   logic              req_fire;
   logic              out_free;

   logic [CFG_W:0]    cfg_sum;
   logic [SIZE_W-1:0] cfg_size;

   mem_wr_type        mem_wr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [7:0]        mem_rdata;
   acc_ctl_type       acc_ctl;
   logic [CNT_W-1:0]  acc_count;

   logic [7:0]        mask;
   logic              hit;
   logic              in_range;
   logic              issue;
   logic              fin_valid;
   logic [1:0]        fin_status;
   logic              fin_bit;
   logic [CNT_W-1:0]  fin_range;
   logic [RES_W-1:0]  fin_data;

   assign req_op    = req_tdata[2:0];
   assign req_pos   = req_tdata[17:3];
   assign req_start = req_tdata[30:18];
   assign req_end   = req_tdata[43:31];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign cfg_sum  = {1'b0, csr_data} + (CFG_W + 1)'(7);
   assign cfg_size = (cfg_sum[CFG_W:3] > (CFG_W - 2)'(MAP_BYTES)) ? SIZE_W'(MAP_BYTES)
                                                                : cfg_sum[SIZE_W+2:3];

   assign mask     = 8'd1 << pos_ff[2:0];
   assign hit      = (mem_rdata & mask) != 8'd0;
   assign in_range = {1'b0, pos_ff[POS_W-1:3]} < size_ff;
   assign issue    = (state_ff == ST_SCAN) && (cnt_ff < end_ff);

   bbb_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   bbb_acc u_acc (
      .clock (clock),
      .reset (reset),
      .ctl   (acc_ctl),
      .data  (mem_rdata),
      .count (acc_count)
   );

   always_comb begin
      unique case (state_ff)
         ST_IDLE: mem_raddr = req_pos[POS_W-1:3];
         ST_SCAN: mem_raddr = cnt_ff[ADDR_W-1:0];
         default: mem_raddr = pos_ff[POS_W-1:3];
      endcase
   end

   always_comb begin
      mem_wr      = '0;
      acc_ctl     = '0;
      used_in     = used_ff;
      fin_valid   = 1'b0;
      fin_status  = STAT_DONE;
      fin_bit     = 1'b0;
      fin_range   = '0;
      acc_ctl.add = pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            acc_ctl.clear = req_fire;
            if (req_fire && req_op > OP_CLEAR_ALL) begin
               fin_valid  = 1'b1;
               fin_status = STAT_RANGE;
            end
         end
         ST_POINT: begin
            fin_valid = 1'b1;
            if (!in_range) begin
               fin_status = STAT_RANGE;
            end else if (op_ff == OP_SET) begin
               if (hit) begin
                  fin_status = STAT_SAME;
               end else begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = pos_ff[POS_W-1:3];
                  mem_wr.data = mem_rdata | mask;
                  used_in     = (used_ff == '1) ? used_ff : used_ff + CNT_W'(1);
               end
            end else if (op_ff == OP_CLEAR) begin
               if (!hit) begin
                  fin_status = STAT_SAME;
               end else begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = pos_ff[POS_W-1:3];
                  mem_wr.data = mem_rdata & ~mask;
                  used_in     = (used_ff == '0) ? used_ff : used_ff - CNT_W'(1);
               end
            end else begin
               fin_bit = hit;
            end
         end
         ST_SCAN: begin
            if (!issue && !pend_ff) begin
               fin_valid  = 1'b1;
               fin_range  = acc_count;
               fin_status = clamp_ff ? STAT_RANGE : STAT_DONE;
               if (op_ff == OP_RECOUNT) begin
                  used_in = acc_count;
               end
            end
         end
         ST_CLEAR: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = clr_ff;
            mem_wr.data = 8'd0;
            used_in     = '0;
            fin_valid   = clr_rsp_ff && (clr_ff == '1);
         end
         ST_RESULT: begin
         end
         default: begin
         end
      endcase
   end

   assign fin_data = {used_in, fin_range, fin_bit, fin_status};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         used_ff      <= '0;
         size_ff      <= SIZE_W'(MAP_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         pend_ff <= issue;
         if (csr_valid && csr_ready) begin
            size_ff <= cfg_size;
         end
         if (issue) begin
            cnt_ff <= cnt_ff + SIZE_W'(1);
         end
         if (fin_valid && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= fin_data;
         end else if (state_ff == ST_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res_data_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fin_valid) begin
            res_data_ff <= fin_data;
            state_ff    <= out_free ? ST_IDLE : ST_RESULT;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
                  if (req_fire) begin
                     op_ff  <= req_op;
                     pos_ff <= req_pos;
                     priority if (req_op == OP_SET || req_op == OP_CLEAR ||
                                  req_op == OP_READ) begin
                        state_ff <= ST_POINT;
                     end else if (req_op == OP_COUNT) begin
                        state_ff <= ST_SCAN;
                        cnt_ff   <= req_start;
                        end_ff   <= (req_end > size_ff) ? size_ff : req_end;
                        clamp_ff <= req_end > size_ff;
                     end else if (req_op == OP_RECOUNT) begin
                        state_ff <= ST_SCAN;
                        cnt_ff   <= '0;
                        end_ff   <= size_ff;
                        clamp_ff <= 1'b0;
                     end else begin
                        state_ff   <= ST_CLEAR;
                        clr_ff     <= '0;
                        clr_rsp_ff <= 1'b1;
                     end
                  end
               end
               ST_CLEAR: begin
                  clr_ff <= clr_ff + ADDR_W'(1);
                  if (clr_ff == '1) begin
                     state_ff <= ST_IDLE;
                  end
               end
               ST_RESULT: begin
                  if (out_free) begin
                     state_ff <= ST_IDLE;
                  end
               end
               ST_POINT, ST_SCAN: begin
               end
               default: begin
                  state_ff <= ST_IDLE;
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - RES_W){1'b0}}, rsp_data_ff};

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAP_BYTES * 8))
      else $error("marked count above store capacity");

   a_point_next: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == OP_SET || req_op == OP_CLEAR || req_op == OP_READ)
      |=> state_ff == ST_POINT)
      else $error("point item did not enter modify step");

   a_clear_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> mem_wr.en && mem_wr.data == 8'd0)
      else $error("clearing sweep skipped a byte");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> end_ff <= size_ff)
      else $error("scan end beyond active size");

endmodule

[src/bbb_mem.sv]
// byte store of the bitmap, one write and one registered read port
// depends on bbb_pkg
module bbb_mem
   import bbb_pkg::*;
(
   input  logic              clock,
   input  mem_wr_type        wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [MAP_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bbb_acc.sv]
// shared population count accumulator, one byte per cycle
// depends on bbb_pkg
module bbb_acc
   import bbb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  acc_ctl_type      ctl,
   input  logic [7:0]       data,
   output logic [CNT_W-1:0] count
);

   function automatic logic [3:0] ones8(input logic [7:0] v);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) begin
         c = c + {3'd0, v[i]};
      end
      return c;
   endfunction

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W:0]   sum;

   always_comb begin
      sum      = {1'b0, count_ff} + {{(CNT_W - 3){1'b0}}, ones8(data)};
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.add) begin
         count_in = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// testbench for bad_block_bitmap: directed and random bitmap operations over
// several map sizes, with a scoreboard class that predicts every reply
// depends on bbb_pkg and the bad_block_bitmap rtl
module testbench;
   import bbb_pkg::*;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      logic [1:0]  status;
      logic        bit_value;
      logic [15:0] range_count;
      logic [15:0] used_count;
   } reply_type;

   class scoreboard_type;
      logic [7:0]  bitmap_copy [MAP_BYTES];
      logic [15:0] marked_copy;
      logic [15:0] map_bits;
      reply_type   replies_due [$];
      int          errors;
      int          checked;

      function new();
         wipe();
         map_bits = 16'd32768;
         errors   = 0;
         checked  = 0;
      endfunction

      function void wipe();
         foreach (bitmap_copy[i]) bitmap_copy[i] = 8'h00;
         marked_copy = 16'd0;
      endfunction

      function int active_size();
         int n;
         n = (int'(map_bits) + 7) >> 3;
         return (n > MAP_BYTES) ? MAP_BYTES : n;
      endfunction

      function logic [15:0] count_bytes(int from, int upto);
         int total;
         total = 0;
         for (int i = from; i < upto && i < MAP_BYTES; i++)
            total += $countones(bitmap_copy[i]);
         return (total > 65535) ? 16'hFFFF : total[15:0];
      endfunction

      function void write_size(logic [15:0] value);
         map_bits = value;
      endfunction

      function void predict_reply(logic [2:0] op, logic [14:0] pos,
                                  logic [12:0] first, logic [12:0] last);
         reply_type   r;
         int          size;
         int          idx;
         int          span_end;
         logic [7:0]  mask;
         size          = active_size();
         idx           = int'(pos) >> 3;
         mask          = 8'd1 << pos[2:0];
         r.status      = STAT_DONE;
         r.bit_value   = 1'b0;
         r.range_count = 16'd0;
         case (op)
            OP_SET, OP_CLEAR, OP_READ: begin
               if (idx >= size) begin
                  r.status = STAT_RANGE;
               end else if (op == OP_SET) begin
                  if ((bitmap_copy[idx] & mask) == 8'h00) begin
                     bitmap_copy[idx] = bitmap_copy[idx] | mask;
                     if (marked_copy != 16'hFFFF) marked_copy++;
                  end else begin
                     r.status = STAT_SAME;
                  end
               end else if (op == OP_CLEAR) begin
                  if ((bitmap_copy[idx] & mask) != 8'h00) begin
                     bitmap_copy[idx] = bitmap_copy[idx] & ~mask;
                     if (marked_copy != 16'd0) marked_copy--;
                  end else begin
                     r.status = STAT_SAME;
                  end
               end else begin
                  r.bit_value = ((bitmap_copy[idx] & mask) != 8'h00);
               end
            end
            OP_COUNT: begin
               span_end = int'(last);
               if (span_end > size) begin
                  span_end = size;
                  r.status = STAT_RANGE;
               end
               r.range_count = count_bytes(int'(first), span_end);
            end
            OP_RECOUNT: begin
               r.range_count = count_bytes(0, size);
               marked_copy   = r.range_count;
            end
            OP_CLEAR_ALL: begin
               wipe();
            end
            default: begin
               r.status = STAT_RANGE;
            end
         endcase
         r.used_count = marked_copy;
         replies_due.push_back(r);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task compare_reply(logic [RSP_W-1:0] d);
         reply_type want;
         if (replies_due.size() == 0) begin
            report($sformatf("reply %h with nothing outstanding", d));
            return;
         end
         want = replies_due.pop_front();
         checked++;
         if (d[1:0] !== want.status)
            report($sformatf("reply %0d status %0d, want %0d", checked, d[1:0], want.status));
         if (d[2] !== want.bit_value)
            report($sformatf("reply %0d bit %0b, want %0b", checked, d[2], want.bit_value));
         if (d[18:3] !== want.range_count)
            report($sformatf("reply %0d range count %0d, want %0d",
                             checked, d[18:3], want.range_count));
         if (d[34:19] !== want.used_count)
            report($sformatf("reply %0d used count %0d, want %0d",
                             checked, d[34:19], want.used_count));
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // opcode, bit_position, start_byte, end_byte
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // status, bit_value, range_count, used_count
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data;

   scoreboard_type   sb;
   bit               quiet;
   int               gap_pct;
   int               stall_pct;
   int               op_seen [8];
   int               items_sent;

   bad_block_bitmap dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   // receiver with random stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && stall_left > 0) begin
            stall_left--;
            rsp_tready = 1'b0;
         end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.compare_reply(rsp_tdata);
      if (!reset && csr_valid && csr_ready) sb.write_size(csr_data);
   end

   task automatic send_item(input logic [2:0] op, input logic [14:0] pos,
                            input logic [12:0] first, input logic [12:0] last);
      @(negedge clock);
      if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, last, first, pos, op};
      do @(posedge clock); while (!req_tready);
      sb.predict_reply(op, pos, first, last);
      op_seen[op]++;
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic apply_size(input logic [15:0] map_bits);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = map_bits;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_item();
      logic [2:0]  op;
      logic [14:0] pos;
      logic [12:0] first;
      logic [12:0] last;
      int          size;
      int          limit;
      int          r;
      int          pick;
      size  = sb.active_size();
      limit = size * 8;
      pos   = 15'($urandom);
      first = 13'($urandom);
      last  = 13'($urandom);
      r     = $urandom_range(0, 99);
      if (r < 35)      op = OP_SET;
      else if (r < 60) op = OP_CLEAR;
      else if (r < 75) op = OP_READ;
      else if (r < 89) op = OP_COUNT;
      else if (r < 94) op = OP_RECOUNT;
      else if (r < 95) op = OP_CLEAR_ALL;
      else             op = (r < 98) ? OP_SPARE_6 : OP_SPARE_7;
      pick = $urandom_range(0, 99);
      if (op == OP_SET || op == OP_CLEAR || op == OP_READ) begin
         // mostly in range and clustered, so bits get set and cleared again
         if (limit > 0 && pick < 60)
            pos = 15'($urandom_range(0, ((limit < 256) ? limit : 256) - 1));
         else if (limit > 0 && pick < 75)
            pos = 15'($urandom_range(0, limit - 1));
         else if (pick < 85)
            pos = 15'(limit + int'($urandom_range(0, 9)) - 5);
      end else if (op == OP_COUNT) begin
         if (pick < 75) begin
            first = 13'($urandom_range(0, size));
            last  = 13'(int'(first) + int'($urandom_range(0, 24)));
         end else if (pick < 85) begin
            first = 13'($urandom_range(0, size));
            last  = 13'(size + int'($urandom_range(0, 2)) - 1);
         end
      end
      send_item(op, pos, first, last);
   endtask

   initial begin
      logic [15:0] sizes [10];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      quiet      = 1'b0;
      gap_pct    = 0;
      stall_pct  = 0;
      items_sent = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      sb = new();
      sizes = '{16'd65535, 16'd1, 16'd64, 16'd777, 16'd32768,
                16'd0, 16'd8, 16'd4000, 16'd32767, 16'd200};
      sizes[5] = 16'($urandom_range(0, 1024));
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // full size after reset
      send_item(OP_SET, 15'd0, 13'd0, 13'd0);
      send_item(OP_SET, 15'd0, 13'd0, 13'd0);
      send_item(OP_SET, 15'h7FFF, 13'd0, 13'd0);
      send_item(OP_READ, 15'h7FFF, 13'd0, 13'd0);
      send_item(OP_READ, 15'd5, 13'd0, 13'd0);
      send_item(OP_CLEAR, 15'd0, 13'd0, 13'd0);
      send_item(OP_CLEAR, 15'd0, 13'd0, 13'd0);
      send_item(OP_COUNT, 15'd0, 13'd0, 13'd4096);
      send_item(OP_COUNT, 15'd0, 13'd4000, 13'h1FFF);
      send_item(OP_COUNT, 15'd0, 13'd10, 13'd5);
      send_item(OP_COUNT, 15'd0, 13'h1FFF, 13'h1FFF);
      send_item(OP_RECOUNT, 15'd0, 13'd0, 13'd0);
      send_item(OP_SPARE_6, 15'd0, 13'd0, 13'd0);
      send_item(OP_SPARE_7, 15'h7FFF, 13'h1FFF, 13'h1FFF);
      send_item(OP_CLEAR_ALL, 15'd0, 13'd0, 13'd0);
      send_item(OP_READ, 15'h7FFF, 13'd0, 13'd0);

      // two bytes active, the upper bits of the last byte still in range
      apply_size(16'd13);
      send_item(OP_SET, 15'd15, 13'd0, 13'd0);
      send_item(OP_SET, 15'd16, 13'd0, 13'd0);
      send_item(OP_CLEAR, 15'd16, 13'd0, 13'd0);
      send_item(OP_READ, 15'd15, 13'd0, 13'd0);
      send_item(OP_COUNT, 15'd0, 13'd0, 13'd3);
      send_item(OP_RECOUNT, 15'd0, 13'd0, 13'd0);

      // empty map
      apply_size(16'd0);
      send_item(OP_SET, 15'd0, 13'd0, 13'd0);
      send_item(OP_COUNT, 15'd0, 13'd0, 13'd0);
      send_item(OP_RECOUNT, 15'd0, 13'd0, 13'd0);

      for (int p = 0; p < 10; p++) begin
         if (p == 9) quiet = 1'b1;
         apply_size(sizes[p]);
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 5;
            default: gap_pct = 25;
         endcase
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 5;
            default: stall_pct = 25;
         endcase
         for (int n = 0; n < 173; n++) begin
            if (n == 90) drain();
            random_item();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.replies_due.size() != 0)
         sb.report($sformatf("%0d replies never arrived", sb.replies_due.size()));
      $display("covered %0d items, %0d replies checked, 13 map sizes from 0 to 65535",
               items_sent, sb.checked);
      $display("set %0d clear %0d read %0d count %0d recount %0d clear-all %0d unknown %0d",
               op_seen[OP_SET], op_seen[OP_CLEAR], op_seen[OP_READ], op_seen[OP_COUNT],
               op_seen[OP_RECOUNT], op_seen[OP_CLEAR_ALL],
               op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7]);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
